// File: rtl/sfud_pkg.sv
// Shared constants, codes and types for the framed byte-stream deframer.
package sfud_pkg;

  localparam int unsigned FieldBytesDefault = 2;

  localparam logic [7:0] SYNC_FIRST  = 8'hEF;
  localparam logic [7:0] SYNC_SECOND = 8'hFE;

  localparam logic [2:0] PH_SOURCE  = 3'd1;
  localparam logic [2:0] PH_DEST    = 3'd2;
  localparam logic [2:0] PH_COMMAND = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_TAIL    = 3'd6;
  localparam logic [2:0] PH_IDLE    = 3'd7;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] source_id;
    logic [15:0] dest_id;
    logic [15:0] command;
    logic [15:0] payload_length;
  } result_t;

  // Only the two low byte positions of a field land in the 16-bit word.
  function automatic logic [15:0] add_byte(input logic [15:0] word,
                                           input logic [15:0] pos,
                                           input logic [7:0]  b);
    logic [15:0] part;
    part = '0;
    if (pos == 16'd0) begin
      part = {8'h00, b};
    end else if (pos == 16'd1) begin
      part = {b, 8'h00};
    end
    return word + part;
  endfunction

endpackage

// File: rtl/sync_framed_uart_deframer_core.sv
// Framed byte-stream deframer: sync detect, header capture, payload stream, tail check.
// A result is registered and shows in the cycle after its byte if the result
// register is free. Takes one byte per cycle unless stalled, one parse pass each.
// A two-entry output stage (result register plus skid register) keeps input flowing
// while a result waits; input stalls only when both entries are full.
// Reset (rst_ni low, asynchronous): parser idle, header words and tail register cleared.
module sync_framed_uart_deframer_core
  import sfud_pkg::*;
#(
  parameter int unsigned FIELD_BYTES = FieldBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] source_id_o,
  output logic [15:0] dest_id_o,
  output logic [15:0] command_o,
  output logic [15:0] payload_length_o
);

  localparam logic [16:0] FieldLen = 17'(FIELD_BYTES);

  logic [15:0] exp_tail_q;
  logic [7:0]  prev_q, prev_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] tail_q, tail_d;

  logic        accept;
  logic        res_valid;
  result_t     res;
  logic [16:0] cnt_inc;
  logic        fdone;
  logic [15:0] tail_sum;

  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        pop, push;

  assign accept  = in_valid_i && in_ready_o;
  assign cnt_inc = {1'b0, cnt_q} + 17'd1;
  assign fdone   = (cnt_inc >= FieldLen);
  assign tail_sum = add_byte(tail_q, cnt_q, rx_byte_i);

  always_comb begin
    prev_d    = rx_byte_i;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    src_d     = src_q;
    dst_d     = dst_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    tail_d    = tail_q;
    res_valid = 1'b0;
    res       = '0;

    if (prev_q == SYNC_FIRST && rx_byte_i == SYNC_SECOND) begin
      cnt_d   = '0;
      src_d   = '0;
      dst_d   = '0;
      cmd_d   = '0;
      len_d   = '0;
      tail_d  = '0;
      phase_d = PH_SOURCE;
    end else begin
      case (phase_q)
        PH_SOURCE: begin
          src_d = add_byte(src_q, cnt_q, rx_byte_i);
          cnt_d = fdone ? 16'd0 : cnt_inc[15:0];
          if (fdone) phase_d = PH_DEST;
        end
        PH_DEST: begin
          dst_d = add_byte(dst_q, cnt_q, rx_byte_i);
          cnt_d = fdone ? 16'd0 : cnt_inc[15:0];
          if (fdone) phase_d = PH_COMMAND;
        end
        PH_COMMAND: begin
          cmd_d = add_byte(cmd_q, cnt_q, rx_byte_i);
          cnt_d = fdone ? 16'd0 : cnt_inc[15:0];
          if (fdone) begin
            phase_d = PH_LENGTH;
            len_d   = '0;
          end
        end
        PH_LENGTH: begin
          len_d = add_byte(len_q, cnt_q, rx_byte_i);
          cnt_d = fdone ? 16'd0 : cnt_inc[15:0];
          if (fdone) phase_d = (len_d != 16'd0) ? PH_PAYLOAD : PH_TAIL;
        end
        PH_PAYLOAD: begin
          res_valid      = 1'b1;
          res.kind       = KIND_PAYLOAD;
          res.data_byte  = rx_byte_i;
          res.byte_index = cnt_q;
          if (cnt_inc >= {1'b0, len_q}) begin
            cnt_d   = '0;
            phase_d = PH_TAIL;
            tail_d  = '0;
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
        PH_TAIL: begin
          tail_d = tail_sum;
          cnt_d  = fdone ? 16'd0 : cnt_inc[15:0];
          if (fdone) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = (tail_sum == exp_tail_q) ? KIND_ACCEPT : KIND_REJECT;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // header fields carry the values current after this byte
    res.source_id      = src_d;
    res.dest_id        = dst_d;
    res.command        = cmd_d;
    res.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_tail_q <= '0;
    end else if (cfg_we_i) begin
      exp_tail_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      tail_q  <= '0;
    end else if (accept) begin
      prev_q  <= prev_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      tail_q  <= tail_d;
    end
  end

  // Output stage: result register backed by one skid entry.
  assign in_ready_o = !skid_valid_q;
  assign pop        = out_valid_q && out_ready_i;
  assign push       = accept && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign byte_index_o     = out_q.byte_index;
  assign source_id_o      = out_q.source_id;
  assign dest_id_o        = out_q.dest_id;
  assign command_o        = out_q.command;
  assign payload_length_o = out_q.payload_length;

endmodule
